// ===== rtl/irti_pkg.sv =====
// Shared types, constants and calibration tables for the IR range table interpolator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package irti_pkg;

    // Width of one ADC breakpoint, of one distance, and of a table index
    localparam int TBL_W  = 10;
    localparam int CM_W   = 8;
    localparam int TBL_IW = 5;

    localparam int DEF_TABLE_POINTS = 14;
    localparam int DEF_ADC_BITS     = 10;

    localparam logic [TBL_W-1:0] ADC_FAR_LIMIT  = TBL_W'(94);
    localparam logic [TBL_W-1:0] ADC_NEAR_LIMIT = TBL_W'(518);
    localparam logic [CM_W-1:0]  CM_NEAR        = CM_W'(20);
    localparam logic [CM_W-1:0]  CM_FAR         = CM_W'(150);

    // Divider retires DIV_BPS quotient bits per cycle
    localparam int DIV_BPS   = 2;
    localparam int DIV_STEPS = CM_W / DIV_BPS;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic set_far;
        logic set_near;
        logic search_next;
        logic mul_start;
        logic div_step;
        logic res_interp;
        logic out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic below_far;
        logic above_near;
        logic seg_hit;
        logic seg_end;
        logic div_last;
    } sts_t;

    // Descending ADC breakpoints; entries past the calibrated ones read as zero
    function automatic logic [TBL_W-1:0] tbl_adc(input logic [TBL_IW-1:0] idx);
        logic [TBL_W-1:0] v;
        case (idx)
            5'd0:    v = TBL_W'(518);
            5'd1:    v = TBL_W'(409);
            5'd2:    v = TBL_W'(315);
            5'd3:    v = TBL_W'(253);
            5'd4:    v = TBL_W'(215);
            5'd5:    v = TBL_W'(184);
            5'd6:    v = TBL_W'(163);
            5'd7:    v = TBL_W'(145);
            5'd8:    v = TBL_W'(135);
            5'd9:    v = TBL_W'(122);
            5'd10:   v = TBL_W'(114);
            5'd11:   v = TBL_W'(104);
            5'd12:   v = TBL_W'(102);
            5'd13:   v = TBL_W'(94);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [CM_W-1:0] tbl_cm(input logic [TBL_IW-1:0] idx);
        logic [CM_W-1:0] v;
        case (idx)
            5'd0:    v = CM_W'(20);
            5'd1:    v = CM_W'(30);
            5'd2:    v = CM_W'(40);
            5'd3:    v = CM_W'(50);
            5'd4:    v = CM_W'(60);
            5'd5:    v = CM_W'(70);
            5'd6:    v = CM_W'(80);
            5'd7:    v = CM_W'(90);
            5'd8:    v = CM_W'(100);
            5'd9:    v = CM_W'(110);
            5'd10:   v = CM_W'(120);
            5'd11:   v = CM_W'(130);
            5'd12:   v = CM_W'(140);
            5'd13:   v = CM_W'(150);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/irti_ctrl.sv =====
// Controller FSM for the IR range table interpolator.
// Depends on irti_pkg (cmd_t, sts_t).
`timescale 1ns / 1ps
`default_nettype none

module irti_ctrl
    import irti_pkg::*;
(
    input  wire  aclk,
    input  wire  aresetn,
    input  wire  s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  wire  m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_DIV,
        S_INTERP,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd           = '0;
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.below_far) begin
                    cmd.set_far = 1'b1;
                    state_next  = S_FINISH;
                end else if (sts.above_near) begin
                    cmd.set_near = 1'b1;
                    state_next   = S_FINISH;
                end else begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (sts.seg_hit) begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_DIV;
                end else if (sts.seg_end) begin
                    // no segment matched: far distance
                    cmd.set_far = 1'b1;
                    state_next  = S_FINISH;
                end else begin
                    cmd.search_next = 1'b1;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = S_INTERP;
                end
            end
            S_INTERP: begin
                cmd.res_interp = 1'b1;
                state_next     = S_FINISH;
            end
            S_FINISH: begin
                // wait here until the output register is free
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/irti_dpath.sv =====
// Datapath for the IR range table interpolator: segment search, multiply,
// radix-4 restoring divide and output register. Depends on irti_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irti_dpath
    import irti_pkg::*;
#(
    parameter int TABLE_POINTS = DEF_TABLE_POINTS,
    parameter int ADC_BITS     = DEF_ADC_BITS
) (
    input  wire                  aclk,
    input  wire  [ADC_BITS-1:0]  adc_in,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    output logic [CM_W-1:0]      dist_out
);

    localparam int KW  = $clog2(TABLE_POINTS);
    localparam int CW  = (ADC_BITS > TBL_W) ? ADC_BITS : TBL_W;
    localparam int PW  = TBL_W + CM_W;
    localparam int DCW = $clog2(DIV_STEPS);

    logic [ADC_BITS-1:0] adc_reg;
    logic [KW-1:0]       k_reg;
    logic [TBL_W-1:0]    span_reg;
    logic [CM_W-1:0]     d0_reg;
    logic                dir_up_reg;
    logic [TBL_W-1:0]    rem_reg, rem_next;
    logic [CM_W-1:0]     low_reg, low_next;
    logic [CM_W-1:0]     quo_reg, quo_next;
    logic [DCW-1:0]      dcnt_reg;
    logic [CM_W-1:0]     res_reg;
    logic [CM_W-1:0]     dist_reg;

    logic [CW-1:0]    adc_ext, hi_ext, lo_ext;
    logic [TBL_W-1:0] hi, lo, off;
    logic [CM_W-1:0]  d0, d1, dd;
    logic [PW-1:0]    prod;
    logic [KW-1:0]    k_prev;

    assign k_prev  = k_reg - 1'b1;
    assign hi      = tbl_adc(TBL_IW'(k_prev));
    assign lo      = tbl_adc(TBL_IW'(k_reg));
    assign d0      = tbl_cm(TBL_IW'(k_prev));
    assign d1      = tbl_cm(TBL_IW'(k_reg));
    assign adc_ext = CW'(adc_reg);
    assign hi_ext  = CW'(hi);
    assign lo_ext  = CW'(lo);

    assign sts.below_far  = adc_ext < CW'(ADC_FAR_LIMIT);
    assign sts.above_near = adc_ext >= CW'(ADC_NEAR_LIMIT);
    assign sts.seg_hit    = (hi > lo) && (adc_ext < hi_ext) && (adc_ext >= lo_ext);
    assign sts.seg_end    = (k_reg == KW'(TABLE_POINTS - 1));
    assign sts.div_last   = (dcnt_reg == DCW'(DIV_STEPS - 1));

    // off <= span, so prod < span * 2^CM_W and prod's upper part starts below span
    assign off  = TBL_W'(hi_ext - adc_ext);
    assign dd   = (d1 >= d0) ? (d1 - d0) : (d0 - d1);
    assign prod = PW'(off) * PW'(dd);

    always_comb begin
        logic [TBL_W:0]   t;
        logic [TBL_W-1:0] r;
        logic [CM_W-1:0]  l;
        logic [CM_W-1:0]  q;
        r = rem_reg;
        l = low_reg;
        q = quo_reg;
        for (int i = 0; i < DIV_BPS; i++) begin
            t = {r, l[CM_W-1]};
            l = {l[CM_W-2:0], 1'b0};
            if (t >= {1'b0, span_reg}) begin
                t = t - {1'b0, span_reg};
                q = {q[CM_W-2:0], 1'b1};
            end else begin
                q = {q[CM_W-2:0], 1'b0};
            end
            r = t[TBL_W-1:0];
        end
        rem_next = r;
        low_next = l;
        quo_next = q;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            adc_reg <= adc_in;
            k_reg   <= KW'(1);
        end else if (cmd.search_next) begin
            k_reg <= k_reg + 1'b1;
        end

        if (cmd.mul_start) begin
            span_reg   <= hi - lo;
            d0_reg     <= d0;
            dir_up_reg <= (d1 >= d0);
            rem_reg    <= prod[PW-1:CM_W];
            low_reg    <= prod[CM_W-1:0];
            quo_reg    <= '0;
            dcnt_reg   <= '0;
        end else if (cmd.div_step) begin
            rem_reg  <= rem_next;
            low_reg  <= low_next;
            quo_reg  <= quo_next;
            dcnt_reg <= dcnt_reg + 1'b1;
        end

        if (cmd.set_far) begin
            res_reg <= CM_FAR;
        end else if (cmd.set_near) begin
            res_reg <= CM_NEAR;
        end else if (cmd.res_interp) begin
            res_reg <= dir_up_reg ? (d0_reg + quo_reg) : (d0_reg - quo_reg);
        end

        if (cmd.out_load) begin
            dist_reg <= res_reg;
        end
    end

    assign dist_out = dist_reg;

endmodule

`default_nettype wire

// ===== rtl/ir_range_table_interpolator.sv =====
// Top level of the IR range table interpolator: ADC reading in, distance in cm out.
// Depends on irti_pkg, irti_ctrl and irti_dpath.
//
//  channel | direction | tdata fields (low bit up)          | accepted when
//  s_      | in        | adc_value[ADC_BITS-1:0], zero pad   | s_tvalid && s_tready
//  m_      | out       | distance_cm[7:0]                    | m_tvalid && m_tready
//
// One item at a time. A reading that clamps to a table end goes from the check
// straight to finish; one that falls in segment k (1..13) passes through search,
// divide and interpolate first. The segment search walks one breakpoint per cycle,
// then the divider retires two quotient bits per cycle until the quotient is complete.
// aresetn is synchronous, active low; it clears the controller and m_tvalid.
// A stalled result sits in the output register; the block takes the next item
// meanwhile and holds its own result until the register frees up.
`timescale 1ns / 1ps
`default_nettype none

module ir_range_table_interpolator
    import irti_pkg::*;
#(
    parameter int TABLE_POINTS = DEF_TABLE_POINTS,
    parameter int ADC_BITS     = DEF_ADC_BITS
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [((ADC_BITS+7)/8)*8-1:0]     s_tdata,   // adc_value
    output logic                              m_tvalid,
    input  wire                               m_tready,
    output logic [CM_W-1:0]                   m_tdata    // distance_cm
);

    cmd_t cmd;
    sts_t sts;

    irti_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    irti_dpath #(
        .TABLE_POINTS (TABLE_POINTS),
        .ADC_BITS     (ADC_BITS)
    ) u_dpath (
        .aclk     (aclk),
        .adc_in   (s_tdata[ADC_BITS-1:0]),
        .cmd      (cmd),
        .sts      (sts),
        .dist_out (m_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/irti_chk.sv =====
// Port-level checker for the IR range table interpolator, bound to the top level.
// Depends on irti_pkg and ir_range_table_interpolator.
`timescale 1ns / 1ps
`default_nettype none

module irti_chk
    import irti_pkg::*;
#(
    parameter int ADC_BITS = DEF_ADC_BITS
) (
    input wire                           aclk,
    input wire                           aresetn,
    input wire                           s_tvalid,
    input wire                           s_tready,
    input wire [((ADC_BITS+7)/8)*8-1:0]  s_tdata,
    input wire                           m_tvalid,
    input wire                           m_tready,
    input wire [CM_W-1:0]                m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // one item in flight: taking an item drops ready
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready stayed high after an accepted item");

    // a result only appears while an item is being worked on
    a_out_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared with no item in progress");

    // distance stays within the table ends
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata >= CM_NEAR) && (m_tdata <= CM_FAR))
        else $error("distance outside table range");

endmodule

bind ir_range_table_interpolator irti_chk #(.ADC_BITS(ADC_BITS)) u_irti_chk (.*);

`default_nettype wire
